[hdl/prf_pkg.sv]
package prf_pkg;

   // field widths
   localparam int CHAR_W = 8;
   localparam int ARG_W = 32;
   localparam int NIBBLE_W = 4;

   // digit counts
   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS = ARG_W / NIBBLE_W;
   localparam int DEF_MAX_DIGITS = 10;

   // binary to bcd conversion: one nibble of the argument per step
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS = ARG_W / BITS_PER_STEP;
   localparam int STEP_CNT_W = $clog2(CONV_STEPS + 1);

   // byte codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_HEXLOW = 8'h60;
   localparam logic [CHAR_W-1:0] BYTE_PERCENT = 8'h25;
   localparam logic [CHAR_W-1:0] BYTE_D = 8'h64;
   localparam logic [CHAR_W-1:0] BYTE_X = 8'h78;
   localparam logic [CHAR_W-1:0] BYTE_NUL = 8'h00;

   // control into the digit shifter
   typedef struct packed {
      logic load;
      logic advance;
      logic keep_zeros;
   } shift_ctrl_type;

   // status out of the digit shifter
   typedef struct packed {
      logic valid;
      logic last;
      logic [NIBBLE_W-1:0] digit;
   } digit_stat_type;

   // digit value to ascii, lowercase hex letters
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [NIBBLE_W-1:0] d);
      logic [CHAR_W-1:0] wide;
      wide = {{(CHAR_W - NIBBLE_W){1'b0}}, d};
      if (d < 4'd10) begin
         return wide + ASCII_ZERO;
      end
      return wide - 8'd9 + ASCII_HEXLOW;
   endfunction

endpackage

[hdl/prf_req_if.sv]
interface prf_req_if import prf_pkg::*; ();
   logic valid;
   logic ready;
   logic [CHAR_W-1:0] format_char;
   logic [ARG_W-1:0] arg_value;

   modport source (output valid, output format_char, output arg_value, input ready);
   modport sink (input valid, input format_char, input arg_value, output ready);
endinterface

[hdl/prf_rsp_if.sv]
interface prf_rsp_if import prf_pkg::*; ();
   logic valid;
   logic ready;
   logic [CHAR_W-1:0] out_char;
   logic last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink (input valid, input out_char, input last, output ready);
endinterface

[hdl/printf_int_formatter.sv]
// Integer formatter for a printf-style byte stream. Each req transfer carries one format
// byte and a 32-bit argument. An ordinary byte comes out as one rsp byte with last set, a
// NUL comes out as 0x00, '%' arms a conversion and gives nothing, and the next byte picks
// it: 'd' prints the argument as unsigned decimal, 'x' as lowercase hex, most significant
// digit first without leading zeros; any other byte there but NUL is dropped. A hex
// conversion loads the argument into the digit shifter (MAX_DIGITS digit positions, capped
// at 10), whose leading zeros are shifted out one per cycle and whose digits leave one per
// cycle unless rsp stalls. A decimal conversion first runs the binary to BCD converter,
// which takes one argument nibble per cycle and then flags done. Values needing more than
// MAX_DIGITS digits keep only their low digits, with zeros included for decimal. The output
// is registered, and stalls on rsp simply hold the digit stream.
module printf_int_formatter import prf_pkg::*; #(
   parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
   input logic        clock,
   input logic        reset,
   prf_req_if.sink    req_bus,
   prf_rsp_if.source  rsp_bus
);

   localparam int NUM_DIGITS = (MAX_DIGITS < DEC_DIGITS) ? MAX_DIGITS : DEC_DIGITS;
   localparam int DIG_W = NUM_DIGITS * NIBBLE_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic pending_ff, pending_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic rsp_last_ff, rsp_last_in;

   logic out_free;
   logic req_fire;
   logic conv_start;
   logic conv_done;
   logic conv_overflow;
   logic [DIG_W-1:0] conv_bcd;
   logic [DIG_W-1:0] load_digits;
   shift_ctrl_type shift_ctrl;
   digit_stat_type digit_stat;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire = req_bus.valid && req_bus.ready;

   // decimal digits come from the converter, hex digits straight from the argument
   assign load_digits = (state_ff == ST_CONV) ? conv_bcd : DIG_W'(req_bus.arg_value);

   prf_bcd_conv #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_conv (
      .clock    (clock),
      .reset    (reset),
      .start    (conv_start),
      .value    (req_bus.arg_value),
      .done     (conv_done),
      .overflow (conv_overflow),
      .bcd      (conv_bcd)
   );

   prf_digit_shift #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_shift (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (shift_ctrl),
      .load_digits (load_digits),
      .stat        (digit_stat)
   );

   // control and output register
   always_comb begin
      state_in = state_ff;
      pending_in = pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      conv_start = 1'b0;
      shift_ctrl.load = 1'b0;
      shift_ctrl.advance = 1'b0;
      shift_ctrl.keep_zeros = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (pending_ff) begin
                  pending_in = 1'b0;
                  if (req_bus.format_char == BYTE_D) begin
                     conv_start = 1'b1;
                     state_in = ST_CONV;
                  end else if (req_bus.format_char == BYTE_X) begin
                     shift_ctrl.load = 1'b1;
                     state_in = ST_EMIT;
                  end else if (req_bus.format_char == BYTE_NUL) begin
                     rsp_valid_in = 1'b1;
                     rsp_char_in = BYTE_NUL;
                     rsp_last_in = 1'b1;
                  end
               end else if (req_bus.format_char == BYTE_PERCENT) begin
                  pending_in = 1'b1;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in = req_bus.format_char;
                  rsp_last_in = 1'b1;
               end
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               shift_ctrl.load = 1'b1;
               shift_ctrl.keep_zeros = conv_overflow;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (digit_stat.valid && out_free) begin
               shift_ctrl.advance = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in = digit_to_ascii(digit_stat.digit);
               rsp_last_in = digit_stat.last;
               if (digit_stat.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pending_ff <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_char = rsp_char_ff;
   assign rsp_bus.last = rsp_last_ff;

`ifndef SYNTH
   // converter finishes only while a decimal conversion is waiting for it
   a_conv_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> (state_ff == ST_CONV))
      else $error("converter done outside conversion state");

   // digits are offered only while emitting
   a_digit_in_emit: assert property (@(posedge clock) disable iff (reset)
      digit_stat.valid |-> (state_ff == ST_EMIT))
      else $error("digit offered outside emit state");

   // a pending conversion is armed only by a percent transfer
   a_pending_from_percent: assert property (@(posedge clock) disable iff (reset)
      $rose(pending_ff) |-> $past(req_fire && (req_bus.format_char == BYTE_PERCENT)))
      else $error("conversion armed without a percent byte");

   // hex conversion goes straight to emitting
   a_hex_to_emit: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pending_ff && (req_bus.format_char == BYTE_X)) |=> (state_ff == ST_EMIT))
      else $error("hex conversion did not start emitting");
`endif

endmodule

[hdl/prf_bcd_conv.sv]
module prf_bcd_conv import prf_pkg::*; #(
   parameter int NUM_DIGITS = DEC_DIGITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ARG_W-1:0]             value,
   output logic                         done,
   output logic                         overflow,
   output logic [NUM_DIGITS*NIBBLE_W-1:0] bcd
);

   localparam int DIG_W = NUM_DIGITS * NIBBLE_W;

   logic [ARG_W-1:0] bin_ff, bin_in;
   logic [DIG_W-1:0] bcd_ff, bcd_in;
   logic [STEP_CNT_W-1:0] steps_ff, steps_in;
   logic done_ff, done_in;
   logic ovf_ff, ovf_in;

   // one argument nibble per cycle: add-3 correction then shift, four times
   always_comb begin
      logic [DIG_W-1:0] bcd_v;
      logic [ARG_W-1:0] bin_v;
      logic ovf_v;
      bcd_v = bcd_ff;
      bin_v = bin_ff;
      ovf_v = ovf_ff;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_v[d*NIBBLE_W +: NIBBLE_W] >= 4'd5) begin
               bcd_v[d*NIBBLE_W +: NIBBLE_W] = bcd_v[d*NIBBLE_W +: NIBBLE_W] + 4'd3;
            end
         end
         // a set bit leaving the top digit means more digits than are kept
         ovf_v = ovf_v | bcd_v[DIG_W-1];
         bcd_v = {bcd_v[DIG_W-2:0], bin_v[ARG_W-1]};
         bin_v = {bin_v[ARG_W-2:0], 1'b0};
      end

      bin_in = bin_ff;
      bcd_in = bcd_ff;
      ovf_in = ovf_ff;
      steps_in = steps_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in = value;
         bcd_in = '0;
         ovf_in = 1'b0;
         steps_in = STEP_CNT_W'(CONV_STEPS);
      end else if (steps_ff != '0) begin
         bin_in = bin_v;
         bcd_in = bcd_v;
         ovf_in = ovf_v;
         steps_in = steps_ff - STEP_CNT_W'(1);
         done_in = (steps_ff == STEP_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         steps_ff <= steps_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign overflow = ovf_ff;
   assign bcd = bcd_ff;

endmodule

[hdl/prf_digit_shift.sv]
module prf_digit_shift import prf_pkg::*; #(
   parameter int NUM_DIGITS = DEC_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  shift_ctrl_type                ctrl,
   input  logic [NUM_DIGITS*NIBBLE_W-1:0] load_digits,
   output digit_stat_type                stat
);

   localparam int DIG_W = NUM_DIGITS * NIBBLE_W;
   localparam int CNT_W = $clog2(NUM_DIGITS + 1);

   logic [DIG_W-1:0] digits_ff, digits_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic started_ff, started_in;
   logic [NIBBLE_W-1:0] top_digit;
   logic skipping;

   // leading zeros drop out one per cycle, the final digit always stays
   assign top_digit = digits_ff[DIG_W-1 -: NIBBLE_W];
   assign skipping = (count_ff != '0) && (count_ff != CNT_W'(1)) && !started_ff
                     && (top_digit == '0);

   always_comb begin
      digits_in = digits_ff;
      count_in = count_ff;
      started_in = started_ff;
      if (ctrl.load) begin
         digits_in = load_digits;
         count_in = CNT_W'(NUM_DIGITS);
         // keep_zeros, set for a truncated decimal value, prints all kept digits, zeros included
         started_in = ctrl.keep_zeros;
      end else if (skipping || (ctrl.advance && stat.valid)) begin
         digits_in = {digits_ff[DIG_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
         count_in = count_ff - CNT_W'(1);
         started_in = !skipping;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         started_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         started_ff <= started_in;
      end
      digits_ff <= digits_in;
   end

   assign stat.valid = (count_ff != '0) && !skipping;
   assign stat.last = (count_ff == CNT_W'(1));
   assign stat.digit = top_digit;

endmodule

[test/tb_printf_int_formatter.sv]
`timescale 1ns / 100ps

module tb_printf_int_formatter import prf_pkg::*; ();

   localparam int DIGIT_LIMIT = DEF_MAX_DIGITS;
   localparam int HOLD_CYCLES = 300;

   // one expected output byte
   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              last;
   } out_byte_type;

   logic clock = 1'b0;
   logic reset;

   prf_req_if req_bus ();
   prf_rsp_if rsp_bus ();

   printf_int_formatter #(
      .MAX_DIGITS(DIGIT_LIMIT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // formatter model state and expected output bytes
   logic         conv_armed = 1'b0;
   out_byte_type expected_chars[$];
   out_byte_type head_char;

   int failures = 0;
   int format_bytes_sent = 0;
   int out_bytes_checked = 0;
   int conversions_seen = 0;
   logic no_idle = 1'b0;
   logic hold_rsp = 1'b0;
   event hold_rsp_start;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb_printf_int_formatter NOT OK");
      $finish;
   end

   function automatic void push_char(input logic [CHAR_W-1:0] ch, input logic is_last);
      out_byte_type entry;
      entry.out_char = ch;
      entry.last = is_last;
      expected_chars.push_back(entry);
   endfunction

   // digits of value in the given radix, most significant first
   function automatic void push_digits(input logic [ARG_W-1:0] value,
                                       input logic [ARG_W-1:0] radix);
      logic [NIBBLE_W-1:0] digs[DIGIT_LIMIT];
      logic [ARG_W-1:0]    rest;
      logic [CHAR_W-1:0]   ch;
      int                  count;
      count = 0;
      rest = value;
      do begin
         digs[count] = NIBBLE_W'(rest % radix);
         count++;
         rest = rest / radix;
      end while (rest != 0 && count < DIGIT_LIMIT);
      for (int k = count - 1; k >= 0; k--) begin
         if (digs[k] < 4'd10) begin
            ch = {4'b0, digs[k]} + ASCII_ZERO;
         end else begin
            ch = {4'b0, digs[k]} - 8'd9 + ASCII_HEXLOW;
         end
         push_char(ch, k == 0);
      end
   endfunction

   // expected output for one accepted format byte
   function automatic void predict_format_byte(input logic [CHAR_W-1:0] ch,
                                               input logic [ARG_W-1:0] arg);
      if (conv_armed) begin
         conv_armed = 1'b0;
         if (ch == BYTE_D) begin
            push_digits(arg, 10);
            conversions_seen++;
         end else if (ch == BYTE_X) begin
            push_digits(arg, 16);
            conversions_seen++;
         end else if (ch == BYTE_NUL) begin
            push_char(BYTE_NUL, 1'b1);
         end
      end else if (ch == BYTE_PERCENT) begin
         conv_armed = 1'b1;
      end else begin
         push_char(ch, 1'b1);
      end
   endfunction

   // long result hold-off, counted in cycles on its own
   initial begin
      forever begin
         @(hold_rsp_start);
         hold_rsp <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_rsp <= 1'b0;
      end
   end

   // result side: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_bus.ready <= 1'b0;
      end else if (no_idle) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= 22);
      end
   end

   // check every output transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected output byte: out_char %h last %b",
                   rsp_bus.out_char, rsp_bus.last);
            failures++;
         end else begin
            head_char = expected_chars.pop_front();
            out_bytes_checked++;
            if (rsp_bus.out_char !== head_char.out_char) begin
               $error("out_char mismatch: expected %h actual %h",
                      head_char.out_char, rsp_bus.out_char);
               failures++;
            end
            if (rsp_bus.last !== head_char.last) begin
               $error("last mismatch: expected %b actual %b",
                      head_char.last, rsp_bus.last);
               failures++;
            end
         end
      end
   end

   // one format byte transfer, with an occasional gap in front
   task automatic send_format_byte(input logic [CHAR_W-1:0] ch, input logic [ARG_W-1:0] arg);
      if (!no_idle && $urandom_range(99) < 22) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.format_char <= ch;
      req_bus.arg_value <= arg;
      do @(posedge clock); while (!req_bus.ready);
      format_bytes_sent++;
      predict_format_byte(ch, arg);
   endtask

   task automatic send_conversion(input logic [CHAR_W-1:0] letter, input logic [ARG_W-1:0] arg);
      send_format_byte(BYTE_PERCENT, $urandom);
      send_format_byte(letter, arg);
   endtask

   // arguments spread over all digit counts
   function automatic logic [ARG_W-1:0] random_arg();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom >> $urandom_range(31);
         2: return $urandom_range(20);
         default: begin
            case ($urandom_range(4))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               3: return 32'd999_999_999;
               default: return 32'd1_000_000_000;
            endcase
         end
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] random_literal();
      logic [CHAR_W-1:0] ch;
      do ch = CHAR_W'($urandom_range(255)); while (ch == BYTE_PERCENT);
      return ch;
   endfunction

   // literals and conversions, closed by a NUL
   task automatic send_random_string();
      int segs;
      segs = $urandom_range(1, 6);
      repeat (segs) begin
         if ($urandom_range(1)) begin
            send_conversion($urandom_range(1) ? BYTE_D : BYTE_X, random_arg());
         end else begin
            send_format_byte(random_literal(), $urandom);
         end
      end
      send_format_byte(BYTE_NUL, $urandom);
   endtask

   task automatic test_directed_bytes();
      send_format_byte(8'h41, 32'h0000_0000);
      send_format_byte(8'hFF, 32'hFFFF_FFFF);
      send_format_byte(8'h01, 32'h5555_5555);
      send_format_byte(8'h80, 32'hAAAA_AAAA);
      send_format_byte(BYTE_NUL, 32'h0000_0000);
   endtask

   task automatic test_directed_conversions();
      send_conversion(BYTE_D, 32'h0000_0000);
      send_conversion(BYTE_D, 32'hFFFF_FFFF);
      send_conversion(BYTE_X, 32'h0000_0000);
      send_conversion(BYTE_X, 32'hFFFF_FFFF);
      send_conversion(BYTE_D, 32'd1_000_000_000);
   endtask

   task automatic test_directed_corner_cases();
      // bit 31 set prints as unsigned
      send_conversion(BYTE_D, 32'h8000_0000);
      // unknown letter and a second percent are dropped
      send_conversion(8'h71, 32'h1234_5678);
      send_conversion(BYTE_PERCENT, 32'h0000_0007);
      // percent then NUL still ends the string
      send_conversion(BYTE_NUL, 32'h0000_0042);
      // conversion letters without a percent are plain bytes
      send_format_byte(BYTE_D, 32'h0000_0009);
      send_format_byte(BYTE_X, 32'h0000_000F);
   endtask

   task automatic test_random_strings(input int count);
      repeat (count) send_random_string();
   endtask

   // any byte sequence, weighted toward percent and conversion letters
   task automatic test_random_noise(input int count);
      logic [CHAR_W-1:0] ch;
      repeat (count) begin
         case ($urandom_range(19))
            0, 1, 2, 3, 4: ch = BYTE_PERCENT;
            5, 6, 7:       ch = BYTE_D;
            8, 9, 10:      ch = BYTE_X;
            11, 12:        ch = BYTE_NUL;
            default:       ch = CHAR_W'($urandom_range(255));
         endcase
         send_format_byte(ch, random_arg());
      end
   endtask

   task automatic test_burst_strings();
      no_idle = 1'b1;
      repeat (6) send_random_string();
      no_idle = 1'b0;
   endtask

   // long result stall while long conversions keep arriving
   task automatic test_output_backpressure();
      logic [CHAR_W-1:0] letter;
      -> hold_rsp_start;
      repeat (12) begin
         letter = $urandom_range(1) ? BYTE_D : BYTE_X;
         send_conversion(letter, 32'hFFFF_FFFF - $urandom_range(255));
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.format_char <= '0;
      req_bus.arg_value <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_bytes();
      test_directed_conversions();
      test_directed_corner_cases();
      test_random_strings(18);
      test_random_noise(50);
      test_burst_strings();
      test_output_backpressure();
      test_random_strings(4);

      req_bus.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d format bytes with %0d conversions, checked %0d output bytes",
               format_bytes_sent, conversions_seen, out_bytes_checked);
      $display("directed extremes, dropped letters, percent-nul, noise, bursts, long stall");
      if (failures == 0) begin
         $display("tb_printf_int_formatter OK");
      end else begin
         $display("tb_printf_int_formatter NOT OK");
      end
      $finish;
   end

endmodule

[printf_int_formatter.f]
hdl/prf_pkg.sv
hdl/prf_req_if.sv
hdl/prf_rsp_if.sv
hdl/prf_bcd_conv.sv
hdl/prf_digit_shift.sv
hdl/printf_int_formatter.sv
test/tb_printf_int_formatter.sv
